[hdl/tplru_pkg.sv]
// ----------------------------------------------------------------------------
// tplru_pkg
// Shared types and codes for the tree pseudo-LRU replacement block.
// ----------------------------------------------------------------------------
package tplru_pkg;

    localparam int SET_W = 11;
    localparam int WAY_W = 4;

    typedef logic [SET_W-1:0] t_set;
    typedef logic [WAY_W-1:0] t_way;

    // Request codes; the fourth code is unused and changes nothing
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_FILL   = 2'd1,
        OP_ACCESS = 2'd2
    } t_opcode;

    // Request word as it travels to the tree update logic
    typedef struct packed {
        t_opcode opcode;
        t_way    way;
        logic    hit;
        logic    is_write;
        logic    set_ok;
    } t_req;

endpackage

[hdl/tplru_node_ops.sv]
// ----------------------------------------------------------------------------
// tplru_node_ops
// Victim walk and recently-used update over the tree bits of one set.
// ----------------------------------------------------------------------------
module tplru_node_ops
    import tplru_pkg::*;
#(
    parameter int WAYS = 16
) (
    input  t_req               i_req,
    input  logic [WAYS-2:0]    i_bits,
    output logic [WAYS-2:0]    o_bits,
    output logic               o_we,
    output t_way               o_victim
);

    localparam int NODES = WAYS - 1;
    localparam int LV    = $clog2(WAYS);
    localparam int NW    = $clog2(2 * WAYS);

    logic [NW-1:0]    walk_node;
    logic [NODES-1:0] walk_sh;
    logic [NW-1:0]    up_node;
    logic [NW-1:0]    up_parent;
    logic [NODES-1:0] up_bits;
    logic             way_ok;
    logic             touch;

    // Walk from the root: a clear bit goes left, a set bit goes right
    always_comb begin
        walk_node = '0;
        walk_sh   = '0;
        for (int s = 0; s < LV; s++) begin
            if (int'(walk_node) < NODES) begin
                walk_sh = i_bits >> walk_node;
                if (walk_sh[0]) begin
                    walk_node = NW'(2 * int'(walk_node) + 2);
                end else begin
                    walk_node = NW'(2 * int'(walk_node) + 1);
                end
            end
        end
    end

    // Point every ancestor of the touched leaf away from it
    always_comb begin
        up_bits   = i_bits;
        up_node   = NW'(NODES + int'(i_req.way));
        up_parent = '0;
        for (int s = 0; s < LV; s++) begin
            if (up_node != '0) begin
                up_parent = (up_node - NW'(1)) >> 1;
                if (up_node[0]) begin
                    up_bits = up_bits | (NODES'(1) << up_parent);
                end else begin
                    up_bits = up_bits & ~(NODES'(1) << up_parent);
                end
                up_node = up_parent;
            end
        end
    end

    // Decide whether the set is written and what is returned
    always_comb begin
        way_ok   = int'(i_req.way) < WAYS;
        touch    = 1'b0;
        o_victim = '0;
        case (i_req.opcode)
            OP_FIND: begin
                o_victim = i_req.set_ok ? t_way'(int'(walk_node) - NODES) : '0;
            end
            OP_FILL: begin
                touch = i_req.set_ok && way_ok;
            end
            OP_ACCESS: begin
                touch = i_req.set_ok && way_ok && i_req.hit && !i_req.is_write;
            end
            default: begin
                touch = 1'b0;
            end
        endcase
    end

    assign o_we   = touch;
    assign o_bits = up_bits;

endmodule

[hdl/tree_plru_replacement_top.sv]
// ----------------------------------------------------------------------------
// tree_plru_replacement_top
// Tree pseudo-LRU replacement state for a set-associative cache, held in one
// synchronous memory with a read, modify and write-back pipeline.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Word
//  request   i_in_valid / o_in_ready    i_opcode i_set_index i_way i_hit
//                                       i_is_write
//  result    o_out_valid / i_out_ready  o_victim_way
//
//  One word per cycle sustained: the tree memory is read at acceptance and
//  written back as the word leaves the first stage, with the written value
//  forwarded when the next word names the same set. A result passes the
//  first stage, then the result register. After reset a clearing pass writes
//  zero to every set with o_in_ready low. A stalled result holds the pipeline;
//  a new request is still taken while the result register is being emptied.
// ----------------------------------------------------------------------------
module tree_plru_replacement_top
    import tplru_pkg::*;
#(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  t_set       i_set_index,
    input  t_way       i_way,
    input  logic       i_hit,
    input  logic       i_is_write,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_way       o_victim_way
);

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int NODES = WAYS - 1;

    logic [NODES-1:0] r_tree_mem [SETS];
    logic [NODES-1:0] r_rd_data;
    logic [NODES-1:0] r_fwd_data;
    logic             r_fwd;

    logic             r_clr_busy;
    logic [SW-1:0]    r_clr_addr;
    logic [SW-1:0]    n_clr_addr;

    logic             r_s1_vld;
    t_req             r_s1_req;
    logic [SW-1:0]    r_s1_addr;

    logic             r_out_vld;
    t_way             r_victim;

    logic             in_acc;
    logic             out_free;
    logic             s1_adv;
    logic             s1_wr;
    logic             s1_we_raw;
    logic [NODES-1:0] s1_bits;
    logic [NODES-1:0] s1_new;
    t_way             s1_victim;
    logic [SW-1:0]    rd_addr;
    t_req             n_req;
    logic             mem_we;
    logic [SW-1:0]    mem_wa;
    logic [NODES-1:0] mem_wd;

    // Handshake and pipeline advance
    assign out_free   = !r_out_vld || i_out_ready;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_ready = !r_clr_busy && (!r_s1_vld || out_free);
    assign in_acc     = i_in_valid && o_in_ready;

    // Build the request word and the memory address
    always_comb begin
        rd_addr          = SW'(i_set_index);
        n_req.opcode     = t_opcode'(i_opcode);
        n_req.way        = i_way;
        n_req.hit        = i_hit;
        n_req.is_write   = i_is_write;
        n_req.set_ok     = int'(i_set_index) < SETS;
    end

    // Take the forwarded value when the previous word wrote this set
    assign s1_bits = r_fwd ? r_fwd_data : r_rd_data;

    tplru_node_ops #(
        .WAYS (WAYS)
    ) u_node_ops (
        .i_req    (r_s1_req),
        .i_bits   (s1_bits),
        .o_bits   (s1_new),
        .o_we     (s1_we_raw),
        .o_victim (s1_victim)
    );

    assign s1_wr = s1_adv && s1_we_raw;

    // Write port: clearing pass, then write-back
    always_comb begin
        mem_we     = r_clr_busy || s1_wr;
        mem_wa     = r_clr_busy ? r_clr_addr : r_s1_addr;
        mem_wd     = r_clr_busy ? '0 : s1_new;
        n_clr_addr = r_clr_addr + SW'(1);
    end

    // Tree memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree_mem[mem_wa] <= mem_wd;
        end
        if (in_acc) begin
            r_rd_data <= r_tree_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= n_clr_addr;
                if (r_clr_addr == SW'(SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
                r_fwd    <= s1_wr && (r_s1_addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req   <= n_req;
            r_s1_addr  <= rd_addr;
            r_fwd_data <= s1_new;
        end
        if (s1_adv) begin
            r_victim <= s1_victim;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_victim_way = r_victim;

endmodule

[hdl/tplru_checker.sv]
// ----------------------------------------------------------------------------
// tplru_port_checker
// Port-level checks on the replacement block, bound to the top level.
// ----------------------------------------------------------------------------
module tplru_port_checker
    import tplru_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_way       o_victim_way
);

    logic [2:0] r_pend;

    // Count words taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(i_in_valid && o_in_ready)
                      - 3'(o_out_valid && i_out_ready);
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_victim_way))
        else $error("result dropped or changed while stalled");

    // Come out of reset busy clearing, with nothing to deliver
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("handshake active straight after reset");

    // Keep at most two words in flight
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more words in flight than pipeline holds");

    // Deliver no result without a request behind it
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 3'd0)
        else $error("result without outstanding request");

endmodule

bind tree_plru_replacement_top tplru_port_checker u_tplru_checker (.*);

[tb/sv/tplru_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tplru_checker
// Watches both channels of the tree pseudo-LRU block, keeps its own copy of
// every set's tree bits, and checks each result word against the victim
// expected for the request word that caused it.
// ----------------------------------------------------------------------------
module tplru_checker
    import tplru_pkg::*;
#(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_opcode,
    input  t_set       i_set_index,
    input  t_way       i_way,
    input  logic       i_hit,
    input  logic       i_is_write,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_way       i_victim_way,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results,
    output int         o_finds
);

    localparam int NODES = WAYS - 1;

    logic [NODES-1:0] plru_tree [SETS];
    t_way             victim_due[$];
    int               fail_cnt   = 0;
    int               result_cnt = 0;
    int               find_cnt   = 0;

    // Walk from the root: a clear bit goes left, a set bit goes right
    function automatic t_way walk_victim(input logic [NODES-1:0] bits);
        int node;
        node = 0;
        while (node < NODES)
            node = bits[node] ? 2 * node + 2 : 2 * node + 1;
        return t_way'(node - NODES);
    endfunction

    // Point every ancestor of the way's leaf away from it
    function automatic logic [NODES-1:0] mark_used(input logic [NODES-1:0] bits,
                                                   input t_way way);
        int node;
        int parent;
        node = NODES + int'(way);
        while (node > 0) begin
            parent       = (node - 1) / 2;
            bits[parent] = (node == 2 * parent + 1);
            node         = parent;
        end
        return bits;
    endfunction

    always @(posedge i_clk) begin : watch
        t_way due;
        t_way seen;
        if (!i_rst_n) begin
            // Tree store is all zero after reset
            foreach (plru_tree[s]) plru_tree[s] = '0;
            victim_due.delete();
        end else begin
            // Predict the result of an accepted request word
            if (i_in_valid && i_in_ready) begin
                due = '0;
                if (int'(i_set_index) < SETS) begin
                    case (i_opcode)
                        OP_FIND: begin
                            due = walk_victim(plru_tree[i_set_index]);
                            find_cnt++;
                        end
                        OP_FILL: begin
                            if (int'(i_way) < WAYS)
                                plru_tree[i_set_index] =
                                    mark_used(plru_tree[i_set_index], i_way);
                        end
                        OP_ACCESS: begin
                            // Only a read hit refreshes the way
                            if (i_hit && !i_is_write && int'(i_way) < WAYS)
                                plru_tree[i_set_index] =
                                    mark_used(plru_tree[i_set_index], i_way);
                        end
                        default: ;
                    endcase
                end
                victim_due.push_back(due);
            end

            // Compare an accepted result word with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                seen = i_victim_way;
                result_cnt++;
                if (victim_due.size() == 0) begin
                    $error("victim_way: result word with nothing expected, actual %0d",
                           seen);
                    fail_cnt++;
                end else begin
                    due = victim_due.pop_front();
                    if (seen !== due) begin
                        $error("victim_way mismatch: expected %0d, actual %0d", due, seen);
                        fail_cnt++;
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= victim_due.size();
        o_results    <= result_cnt;
        o_finds      <= find_cnt;
    end

endmodule

[tb/sv/tb_tree_plru_replacement_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tree_plru_replacement_top
// Drives request words into the tree pseudo-LRU block: a directed opening on
// reset trees, extreme sets and ignored accesses, then random traffic that
// works a few hot sets hard, with random stalls on both channels. A checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_tree_plru_replacement_top;
    import tplru_pkg::*;

    localparam int         SETS       = 2048;
    localparam int         WAYS       = 16;
    localparam int         WORD_GOAL  = 1900;
    localparam int         CALM_TAIL  = 300;
    localparam int         DRAIN_WAIT = 20;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_opcode;
    t_set       i_set_index;
    t_way       i_way;
    logic       i_hit;
    logic       i_is_write;
    logic       o_out_valid;
    logic       i_out_ready;
    t_way       o_victim_way;

    int fail_count;
    int pending;
    int results;
    int finds;
    int words_sent;
    bit calm;
    bit gaps_on;

    tree_plru_replacement_top #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_set_index  (i_set_index),
        .i_way        (i_way),
        .i_hit        (i_hit),
        .i_is_write   (i_is_write),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_victim_way (o_victim_way)
    );

    tplru_checker #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_set_index  (i_set_index),
        .i_way        (i_way),
        .i_hit        (i_hit),
        .i_is_write   (i_is_write),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_victim_way (o_victim_way),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_finds      (finds)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake
    initial begin
        #5_000_000;
        $error("timeout: run did not complete");
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stall bursts, none once the run has calmed down
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // Present one request word and hold it until taken, then maybe idle
    task automatic send_word(input logic [1:0] op, input t_set set, input t_way way,
                             input logic hit, input logic wr);
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_set_index <= set;
        i_way       <= way;
        i_hit       <= hit;
        i_is_write  <= wr;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        calm = (words_sent >= WORD_GOAL - CALM_TAIL);
        if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Weighted request code: mostly real traffic, now and then the spare code
    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return OP_FIND;
        else if (r < 13)
            return OP_FILL;
        else if (r < 19)
            return OP_ACCESS;
        return OP_SPARE;
    endfunction

    initial begin
        t_set hot_sets[6];
        int   order[WAYS];
        int   pick;
        int   tmp;
        int   burst;
        t_set set;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_FIND;
        i_set_index <= '0;
        i_way       <= '0;
        i_hit       <= 1'b0;
        i_is_write  <= 1'b0;
        words_sent  = 0;
        calm        = 1'b0;
        gaps_on     = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset trees at both ends of the set range
        send_word(OP_FIND,   11'd0,    4'd15, 1'b1, 1'b1);
        send_word(OP_FIND,   11'd2047, 4'd0,  1'b0, 1'b0);
        // Fill the lowest way, then read-hit the way now chosen
        send_word(OP_FILL,   11'd0,    4'd0,  1'b0, 1'b0);
        send_word(OP_FIND,   11'd0,    4'd0,  1'b0, 1'b0);
        send_word(OP_ACCESS, 11'd0,    4'd8,  1'b1, 1'b0);
        send_word(OP_FIND,   11'd0,    4'd0,  1'b0, 1'b0);
        // Write hit and read miss leave the tree alone
        send_word(OP_ACCESS, 11'd0,    4'd15, 1'b1, 1'b1);
        send_word(OP_FIND,   11'd0,    4'd0,  1'b0, 1'b0);
        send_word(OP_ACCESS, 11'd0,    4'd15, 1'b0, 1'b0);
        send_word(OP_ACCESS, 11'd0,    4'd15, 1'b0, 1'b1);
        send_word(OP_FIND,   11'd0,    4'd0,  1'b0, 1'b0);
        // Spare code changes nothing and reports zero
        send_word(OP_SPARE,  11'd0,    4'd15, 1'b1, 1'b0);
        send_word(OP_FIND,   11'd0,    4'd0,  1'b0, 1'b0);
        // Top way of the top set
        send_word(OP_FILL,   11'd2047, 4'd15, 1'b1, 1'b1);
        send_word(OP_FIND,   11'd2047, 4'd15, 1'b1, 1'b1);
        // Back-to-back updates of one set, exercising the forwarding path
        send_word(OP_FILL,   11'd1365, 4'd3,  1'b0, 1'b0);
        send_word(OP_FIND,   11'd1365, 4'd0,  1'b0, 1'b0);
        send_word(OP_ACCESS, 11'd1365, 4'd7,  1'b1, 1'b0);
        send_word(OP_ACCESS, 11'd1365, 4'd12, 1'b1, 1'b0);
        send_word(OP_FIND,   11'd1365, 4'd0,  1'b0, 1'b0);
        send_word(OP_FIND,   11'd682,  4'd10, 1'b0, 1'b1);

        // Random traffic concentrated on a handful of hot sets
        hot_sets[0] = 11'd0;
        hot_sets[1] = 11'd2047;
        for (int h = 2; h < 6; h++) hot_sets[h] = t_set'($urandom_range(0, SETS - 1));

        while (words_sent < WORD_GOAL) begin
            if (words_sent % 64 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            set  = hot_sets[$urandom_range(0, 5)];
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                // Hot-set burst of mixed requests
                burst = $urandom_range(2, 8);
                repeat (burst)
                    send_word(pick_op(), set, t_way'($urandom_range(0, WAYS - 1)),
                              1'($urandom), 1'($urandom));
            end else if (pick < 7) begin
                // Touch every way in a shuffled order, then ask for a victim
                foreach (order[i]) order[i] = i;
                for (int i = WAYS - 1; i > 0; i--) begin
                    tmp = $urandom_range(0, i);
                    {order[i], order[tmp]} = {order[tmp], order[i]};
                end
                foreach (order[i]) begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(OP_FILL, set, t_way'(order[i]), 1'($urandom), 1'($urandom));
                    else
                        send_word(OP_ACCESS, set, t_way'(order[i]), 1'b1, 1'b0);
                end
                send_word(OP_FIND, set, t_way'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick == 7) begin
                // Touch then find on any set
                set = t_set'($urandom_range(0, SETS - 1));
                send_word(OP_FILL, set, t_way'($urandom_range(0, WAYS - 1)), 1'b0, 1'b0);
                send_word(OP_FIND, set, '0, 1'b0, 1'b0);
            end else if (pick == 8) begin
                // Noise: every field drawn over its full range
                send_word(2'($urandom_range(0, 3)), t_set'($urandom_range(0, SETS - 1)),
                          t_way'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                // Repeated finds on one set
                repeat ($urandom_range(2, 4))
                    send_word(OP_FIND, set, t_way'($urandom), 1'($urandom), 1'($urandom));
            end
        end

        // Drain outstanding results
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d request words; %0d results checked, %0d of them victim lookups.",
                 words_sent, results, finds);
        $display("Mismatches: %0d, results still outstanding: %0d.", fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hdl/tplru_pkg.sv
hdl/tplru_node_ops.sv
hdl/tree_plru_replacement_top.sv
hdl/tplru_checker.sv
tb/sv/tplru_checker.sv
tb/sv/tb_tree_plru_replacement_top.sv
